// File: sv/cspg_pkg.sv
// Shared types, widths and helpers of the coordinated step pulse generator.
package cspg_pkg;

   localparam int POS_BITS           = 24;
   localparam int INTERVAL_FRAC_BITS = 8;

   localparam int IN_W      = 24;
   localparam int MPS_W     = 16;
   localparam int FEED_W    = 16;
   localparam int NUM_AXES  = 4;
   localparam int AXIS_W    = 2;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 16;

   localparam int IV_W      = 40;
   localparam int SUM_W     = 48;
   localparam int TRAVEL_W  = POS_BITS + MPS_W;
   localparam int ROOT_W    = TRAVEL_W + 1;
   localparam int SQ_W      = 2 * ROOT_W;
   localparam int SREM_W    = ROOT_W + 3;
   localparam int USEC_W    = 20;
   localparam int SHIFT_W   = INTERVAL_FRAC_BITS + 4;
   localparam int LENP_W    = ROOT_W + USEC_W;
   localparam int NUM_W     = LENP_W + SHIFT_W;
   localparam int DEN_W     = FEED_W + POS_BITS;
   localparam int QSHIFT    = 16;
   localparam int CNT_W     = $clog2(NUM_W);

   localparam logic [USEC_W-1:0] USEC_PER_SEC = USEC_W'(1000000);
   localparam logic [IV_W-1:0]   IV_MAX  = {IV_W{1'b1}};
   localparam logic [IV_W-1:0]   IV_MIN  = IV_W'(1) << INTERVAL_FRAC_BITS;
   localparam logic [SUM_W-1:0]  SUM_MAX = {SUM_W{1'b1}};

   typedef logic signed [POS_BITS-1:0] pos_type;
   typedef logic [POS_BITS-1:0]        steps_type;

   typedef enum logic [1:0] {
      FUNC_TICK   = 2'd0,
      FUNC_MOVE   = 2'd1,
      FUNC_SETPOS = 2'd2
   } func_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_MPS_X = 3'd0,
      REG_MPS_Y = 3'd1,
      REG_MPS_Z = 3'd2,
      REG_FEED  = 3'd3,
      REG_MODE  = 3'd4
   } reg_index_type;

   typedef enum logic [3:0] {
      OP_NONE, OP_CAPTURE, OP_SETPOS, OP_REJECT, OP_SETUP, OP_TRAVEL, OP_MUL_STEP,
      OP_SQ_ACC, OP_SQRT_STEP, OP_LEN_INIT, OP_DIV_INIT, OP_DIV_STEP, OP_DIV_STORE,
      OP_MOVE_END, OP_TICK_AXIS, OP_TICK_END
   } dp_op_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_DECODE, ST_TRAVEL, ST_SQ_MUL, ST_SQ_ACC, ST_SQRT, ST_LEN_INIT,
      ST_LEN_MUL, ST_DIV_PREP, ST_DIV, ST_DIV_STORE, ST_MOVE_END, ST_TICK,
      ST_TICK_END, ST_RESP
   } state_type;

   typedef struct packed {
      dp_op_type          op;
      logic [AXIS_W-1:0]  axis;
      logic               out_load;
   } cmd_type;

   typedef struct packed {
      logic [1:0]          func;
      logic                moving;
      logic [NUM_AXES-1:0] steps_nz;
   } status_type;

   typedef struct packed {
      logic [NUM_AXES-1:0] step_pulses;
      logic [NUM_AXES-1:0] directions;
      logic                busy_res;
      logic                move_done;
      logic                rejected;
   } rsp_data_type;

   // Sign-extends a request field and wraps it to the position width.
   function automatic pos_type to_pos(input logic signed [IN_W-1:0] v);
      logic signed [32:0] ext;
      ext = 33'(v);
      return ext[POS_BITS-1:0];
   endfunction

endpackage

// File: sv/cspg_if.sv
// Handshake channel interfaces: request, response and register write.
interface cspg_req_if;
   logic                                valid;
   logic                                ready;
   logic [1:0]                          func;
   logic signed [cspg_pkg::IN_W-1:0]    target_x;
   logic signed [cspg_pkg::IN_W-1:0]    target_y;
   logic signed [cspg_pkg::IN_W-1:0]    target_z;
   logic signed [cspg_pkg::IN_W-1:0]    target_e;
   modport source (output valid, func, target_x, target_y, target_z, target_e,
                   input ready);
   modport sink   (input valid, func, target_x, target_y, target_z, target_e,
                   output ready);
endinterface

interface cspg_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] step_pulses;
   logic [3:0] directions;
   logic       busy_res;
   logic       move_done;
   logic       rejected;
   modport source (output valid, step_pulses, directions, busy_res, move_done, rejected,
                   input ready);
   modport sink   (input valid, step_pulses, directions, busy_res, move_done, rejected,
                   output ready);
endinterface

interface cspg_csr_if;
   logic                               valid;
   logic                               ready;
   logic [cspg_pkg::CSR_IDX_W-1:0]     index;
   logic [cspg_pkg::CSR_DAT_W-1:0]     data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: sv/cspg_ctrl.sv
// Sequencer for tick handling and move set-up of the step pulse generator.
module cspg_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  cspg_pkg::status_type status,
   output cspg_pkg::cmd_type    cmd
);

   cspg_pkg::state_type                state_ff, state_in;
   logic [cspg_pkg::AXIS_W-1:0]        axis_ff, axis_in;
   logic [cspg_pkg::CNT_W-1:0]         cnt_ff, cnt_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic                               out_free;

   localparam logic [cspg_pkg::CNT_W-1:0] MUL_LAST  = cspg_pkg::CNT_W'(cspg_pkg::ROOT_W - 1);
   localparam logic [cspg_pkg::CNT_W-1:0] SQRT_LAST = cspg_pkg::CNT_W'(cspg_pkg::ROOT_W - 1);
   localparam logic [cspg_pkg::CNT_W-1:0] DIV_LAST  = cspg_pkg::CNT_W'(cspg_pkg::NUM_W - 1);
   localparam logic [cspg_pkg::AXIS_W-1:0] AXIS_Z    = cspg_pkg::AXIS_W'(2);
   localparam logic [cspg_pkg::AXIS_W-1:0] AXIS_LAST = cspg_pkg::AXIS_W'(cspg_pkg::NUM_AXES - 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cspg_pkg::ST_IDLE;
         axis_ff      <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         axis_ff      <= axis_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign req_ready = (state_ff == cspg_pkg::ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      axis_in      = axis_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd.op       = cspg_pkg::OP_NONE;
      cmd.axis     = axis_ff;
      cmd.out_load = 1'b0;
      unique case (state_ff)
         cspg_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.op   = cspg_pkg::OP_CAPTURE;
               state_in = cspg_pkg::ST_DECODE;
            end
         end
         cspg_pkg::ST_DECODE: begin
            axis_in  = '0;
            cnt_in   = '0;
            state_in = cspg_pkg::ST_RESP;
            unique case (status.func)
               cspg_pkg::FUNC_TICK: begin
                  if (status.moving) state_in = cspg_pkg::ST_TICK;
               end
               cspg_pkg::FUNC_MOVE: begin
                  if (status.moving) begin
                     cmd.op = cspg_pkg::OP_REJECT;
                  end else begin
                     cmd.op   = cspg_pkg::OP_SETUP;
                     state_in = cspg_pkg::ST_TRAVEL;
                  end
               end
               cspg_pkg::FUNC_SETPOS: begin
                  cmd.op = status.moving ? cspg_pkg::OP_REJECT : cspg_pkg::OP_SETPOS;
               end
               default: ;
            endcase
         end
         cspg_pkg::ST_TRAVEL: begin
            cmd.op   = cspg_pkg::OP_TRAVEL;
            cnt_in   = '0;
            state_in = cspg_pkg::ST_SQ_MUL;
         end
         cspg_pkg::ST_SQ_MUL: begin
            cmd.op = cspg_pkg::OP_MUL_STEP;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == MUL_LAST) state_in = cspg_pkg::ST_SQ_ACC;
         end
         cspg_pkg::ST_SQ_ACC: begin
            cmd.op = cspg_pkg::OP_SQ_ACC;
            cnt_in = '0;
            if (axis_ff == AXIS_Z) begin
               state_in = cspg_pkg::ST_SQRT;
            end else begin
               axis_in  = axis_ff + 1'b1;
               state_in = cspg_pkg::ST_TRAVEL;
            end
         end
         cspg_pkg::ST_SQRT: begin
            cmd.op = cspg_pkg::OP_SQRT_STEP;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == SQRT_LAST) state_in = cspg_pkg::ST_LEN_INIT;
         end
         cspg_pkg::ST_LEN_INIT: begin
            cmd.op   = cspg_pkg::OP_LEN_INIT;
            cnt_in   = '0;
            state_in = cspg_pkg::ST_LEN_MUL;
         end
         cspg_pkg::ST_LEN_MUL: begin
            cmd.op = cspg_pkg::OP_MUL_STEP;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == MUL_LAST) begin
               axis_in  = '0;
               state_in = cspg_pkg::ST_DIV_PREP;
            end
         end
         cspg_pkg::ST_DIV_PREP: begin
            cnt_in = '0;
            if (status.steps_nz[axis_ff]) begin
               cmd.op   = cspg_pkg::OP_DIV_INIT;
               state_in = cspg_pkg::ST_DIV;
            end else if (axis_ff == AXIS_LAST) begin
               state_in = cspg_pkg::ST_MOVE_END;
            end else begin
               axis_in = axis_ff + 1'b1;
            end
         end
         cspg_pkg::ST_DIV: begin
            cmd.op = cspg_pkg::OP_DIV_STEP;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) state_in = cspg_pkg::ST_DIV_STORE;
         end
         cspg_pkg::ST_DIV_STORE: begin
            cmd.op = cspg_pkg::OP_DIV_STORE;
            if (axis_ff == AXIS_LAST) begin
               state_in = cspg_pkg::ST_MOVE_END;
            end else begin
               axis_in  = axis_ff + 1'b1;
               state_in = cspg_pkg::ST_DIV_PREP;
            end
         end
         cspg_pkg::ST_MOVE_END: begin
            cmd.op   = cspg_pkg::OP_MOVE_END;
            state_in = cspg_pkg::ST_RESP;
         end
         cspg_pkg::ST_TICK: begin
            cmd.op = cspg_pkg::OP_TICK_AXIS;
            if (axis_ff == AXIS_LAST) begin
               state_in = cspg_pkg::ST_TICK_END;
            end else begin
               axis_in = axis_ff + 1'b1;
            end
         end
         cspg_pkg::ST_TICK_END: begin
            cmd.op   = cspg_pkg::OP_TICK_END;
            state_in = cspg_pkg::ST_RESP;
         end
         cspg_pkg::ST_RESP: begin
            // The finished result waits here until the output register frees up.
            if (out_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = cspg_pkg::ST_IDLE;
            end
         end
         default: state_in = cspg_pkg::ST_IDLE;
      endcase
   end

endmodule

// File: sv/cspg_dp.sv
// Datapath: axis state, configuration registers, multiplier, root and divider units.
module cspg_dp (
   input  logic                                   clock,
   input  logic                                   reset,
   input  cspg_pkg::cmd_type                      cmd,
   output cspg_pkg::status_type                   status,
   input  logic [1:0]                             req_func,
   input  logic signed [cspg_pkg::IN_W-1:0]       req_target_x,
   input  logic signed [cspg_pkg::IN_W-1:0]       req_target_y,
   input  logic signed [cspg_pkg::IN_W-1:0]       req_target_z,
   input  logic signed [cspg_pkg::IN_W-1:0]       req_target_e,
   input  logic                                   csr_write,
   input  logic [cspg_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [cspg_pkg::CSR_DAT_W-1:0]         csr_data,
   output cspg_pkg::rsp_data_type                 rsp_data
);

   localparam int NA = cspg_pkg::NUM_AXES;

   logic [cspg_pkg::MPS_W-1:0]     mps_x_ff, mps_y_ff, mps_z_ff;
   logic [cspg_pkg::FEED_W-1:0]    feed_ff;
   logic                           mode_ff;
   logic [1:0]                     func_ff;
   cspg_pkg::pos_type              req_pos_ff   [NA];
   cspg_pkg::pos_type              position_ff  [NA];
   cspg_pkg::pos_type              target_ff    [NA];
   cspg_pkg::steps_type            total_ff     [NA];
   cspg_pkg::steps_type            done_cnt_ff  [NA];
   logic [cspg_pkg::IV_W-1:0]      interval_ff  [NA];
   logic [cspg_pkg::SUM_W-1:0]     isum_ff      [NA];
   logic [cspg_pkg::SUM_W-1:0]     elapsed_ff;
   logic [NA-1:0]                  dir_ff, pulses_ff;
   logic                           moving_ff, move_done_ff, rej_ff;
   logic [cspg_pkg::SQ_W-1:0]      sum_sq_ff, prod_ff;
   logic [cspg_pkg::ROOT_W-1:0]    root_ff, mul_a_ff, mul_b_ff;
   logic [cspg_pkg::SREM_W-1:0]    srem_ff;
   logic [cspg_pkg::NUM_W-1:0]     div_ff;
   logic [cspg_pkg::DEN_W-1:0]     drem_ff, den_ff;
   cspg_pkg::rsp_data_type         out_ff;

   // Move set-up values for all axes.
   logic                           new_dir   [NA];
   cspg_pkg::pos_type              new_tgt   [NA];
   cspg_pkg::steps_type            new_total [NA];
   logic signed [cspg_pkg::POS_BITS:0] diff  [NA];
   logic [NA-1:0]                  steps_nz;
   logic [NA-1:0]                  all_met;

   logic [cspg_pkg::MPS_W-1:0]     mps_sel;
   logic [cspg_pkg::TRAVEL_W-1:0]  travel;
   logic [cspg_pkg::SREM_W-1:0]    srem_shift, sq_trial;
   logic [cspg_pkg::DEN_W:0]       drem_shift;
   logic                           div_ge;
   logic [cspg_pkg::IV_W-1:0]      quot_iv;
   logic [cspg_pkg::IV_W-1:0]      new_iv;
   logic                           tick_hit, tick_open;
   logic [cspg_pkg::SUM_W:0]       isum_add;
   logic [1:0]                     skip_axis;

   assign skip_axis = mode_ff ? 2'd2 : 2'd3;

   always_comb begin
      for (int i = 0; i < NA; i++) begin
         diff[i]      = {req_pos_ff[i][cspg_pkg::POS_BITS-1], req_pos_ff[i]}
                      - {position_ff[i][cspg_pkg::POS_BITS-1], position_ff[i]};
         new_dir[i]   = !(req_pos_ff[i] > position_ff[i]);
         if (2'(i) == skip_axis) begin
            new_tgt[i]   = position_ff[i];
            new_total[i] = '0;
         end else begin
            new_tgt[i]   = req_pos_ff[i];
            new_total[i] = diff[i][cspg_pkg::POS_BITS] ? cspg_pkg::POS_BITS'(-diff[i])
                                                       : cspg_pkg::POS_BITS'(diff[i]);
         end
         steps_nz[i] = (total_ff[i] != '0);
         all_met[i]  = !(done_cnt_ff[i] < total_ff[i]);
      end
   end

   always_comb begin
      case (cmd.axis)
         2'd0:    mps_sel = mps_x_ff;
         2'd1:    mps_sel = mps_y_ff;
         default: mps_sel = mps_z_ff;
      endcase
      travel = cspg_pkg::TRAVEL_W'(total_ff[cmd.axis]) * cspg_pkg::TRAVEL_W'(mps_sel);

      srem_shift = {srem_ff[cspg_pkg::ROOT_W:0], sum_sq_ff[cspg_pkg::SQ_W-1 -: 2]};
      sq_trial   = cspg_pkg::SREM_W'({root_ff, 2'b01});

      drem_shift = {drem_ff, div_ff[cspg_pkg::NUM_W-1]};
      div_ge     = drem_shift >= {1'b0, den_ff};

      // The quotient is shifted down by 16 and clipped to the interval range.
      if (div_ff[cspg_pkg::NUM_W-1:cspg_pkg::IV_W+cspg_pkg::QSHIFT] != '0)
         quot_iv = cspg_pkg::IV_MAX;
      else
         quot_iv = div_ff[cspg_pkg::IV_W+cspg_pkg::QSHIFT-1:cspg_pkg::QSHIFT];
      if (feed_ff == '0)
         new_iv = cspg_pkg::IV_MAX;
      else if (quot_iv < cspg_pkg::IV_MIN)
         new_iv = cspg_pkg::IV_MIN;
      else
         new_iv = quot_iv;

      tick_open = done_cnt_ff[cmd.axis] < total_ff[cmd.axis];
      tick_hit  = {elapsed_ff, cspg_pkg::INTERVAL_FRAC_BITS'(0)}
               >= (cspg_pkg::SUM_W + cspg_pkg::INTERVAL_FRAC_BITS)'(isum_ff[cmd.axis]);
      isum_add  = {1'b0, isum_ff[cmd.axis]} + (cspg_pkg::SUM_W + 1)'(interval_ff[cmd.axis]);
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mps_x_ff <= cspg_pkg::MPS_W'(819);
         mps_y_ff <= cspg_pkg::MPS_W'(819);
         mps_z_ff <= cspg_pkg::MPS_W'(164);
         feed_ff  <= cspg_pkg::FEED_W'(800);
         mode_ff  <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_index)
            cspg_pkg::REG_MPS_X: mps_x_ff <= csr_data;
            cspg_pkg::REG_MPS_Y: mps_y_ff <= csr_data;
            cspg_pkg::REG_MPS_Z: mps_z_ff <= csr_data;
            cspg_pkg::REG_FEED:  feed_ff  <= csr_data;
            cspg_pkg::REG_MODE:  mode_ff  <= csr_data[0];
            default: ;
         endcase
      end
   end

   // Architectural axis state.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NA; i++) begin
            position_ff[i] <= '0;
            target_ff[i]   <= '0;
            total_ff[i]    <= '0;
            done_cnt_ff[i] <= '0;
            interval_ff[i] <= '0;
            isum_ff[i]     <= '0;
         end
         elapsed_ff   <= '0;
         dir_ff       <= '0;
         moving_ff    <= 1'b0;
         move_done_ff <= 1'b0;
         rej_ff       <= 1'b0;
         pulses_ff    <= '0;
      end else begin
         case (cmd.op)
            cspg_pkg::OP_CAPTURE: begin
               pulses_ff    <= '0;
               move_done_ff <= 1'b0;
               rej_ff       <= 1'b0;
            end
            cspg_pkg::OP_REJECT: rej_ff <= 1'b1;
            cspg_pkg::OP_SETPOS: begin
               for (int i = 0; i < NA; i++) position_ff[i] <= req_pos_ff[i];
            end
            cspg_pkg::OP_SETUP: begin
               for (int i = 0; i < NA; i++) begin
                  dir_ff[i]      <= new_dir[i];
                  target_ff[i]   <= new_tgt[i];
                  total_ff[i]    <= new_total[i];
                  done_cnt_ff[i] <= '0;
                  isum_ff[i]     <= '0;
                  interval_ff[i] <= '0;
               end
               elapsed_ff <= '0;
            end
            cspg_pkg::OP_DIV_STORE: interval_ff[cmd.axis] <= new_iv;
            cspg_pkg::OP_MOVE_END: begin
               if (steps_nz != '0) begin
                  moving_ff <= 1'b1;
               end else begin
                  for (int i = 0; i < NA; i++) position_ff[i] <= target_ff[i];
                  move_done_ff <= 1'b1;
               end
            end
            cspg_pkg::OP_TICK_AXIS: begin
               if (tick_open && tick_hit) begin
                  pulses_ff[cmd.axis]   <= 1'b1;
                  done_cnt_ff[cmd.axis] <= done_cnt_ff[cmd.axis] + 1'b1;
                  isum_ff[cmd.axis]     <= isum_add[cspg_pkg::SUM_W] ? cspg_pkg::SUM_MAX
                                         : isum_add[cspg_pkg::SUM_W-1:0];
               end
            end
            cspg_pkg::OP_TICK_END: begin
               if (elapsed_ff != cspg_pkg::SUM_MAX) elapsed_ff <= elapsed_ff + 1'b1;
               if (&all_met) begin
                  for (int i = 0; i < NA; i++) position_ff[i] <= target_ff[i];
                  moving_ff    <= 1'b0;
                  move_done_ff <= 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   // Request capture and arithmetic working registers.
   always_ff @(posedge clock) begin
      case (cmd.op)
         cspg_pkg::OP_CAPTURE: begin
            func_ff       <= req_func;
            req_pos_ff[0] <= cspg_pkg::to_pos(req_target_x);
            req_pos_ff[1] <= cspg_pkg::to_pos(req_target_y);
            req_pos_ff[2] <= cspg_pkg::to_pos(req_target_z);
            req_pos_ff[3] <= cspg_pkg::to_pos(req_target_e);
         end
         cspg_pkg::OP_SETUP: begin
            sum_sq_ff <= '0;
            root_ff   <= '0;
            srem_ff   <= '0;
         end
         cspg_pkg::OP_TRAVEL: begin
            mul_a_ff <= cspg_pkg::ROOT_W'(travel);
            mul_b_ff <= cspg_pkg::ROOT_W'(travel);
            prod_ff  <= '0;
         end
         cspg_pkg::OP_MUL_STEP: begin
            // Most significant multiplier bit first: shift, then add.
            prod_ff  <= {prod_ff[cspg_pkg::SQ_W-2:0], 1'b0}
                      + (mul_b_ff[cspg_pkg::ROOT_W-1] ? cspg_pkg::SQ_W'(mul_a_ff) : '0);
            mul_b_ff <= {mul_b_ff[cspg_pkg::ROOT_W-2:0], 1'b0};
         end
         cspg_pkg::OP_SQ_ACC: sum_sq_ff <= sum_sq_ff + prod_ff;
         cspg_pkg::OP_SQRT_STEP: begin
            sum_sq_ff <= {sum_sq_ff[cspg_pkg::SQ_W-3:0], 2'b00};
            if (srem_shift >= sq_trial) begin
               srem_ff <= srem_shift - sq_trial;
               root_ff <= {root_ff[cspg_pkg::ROOT_W-2:0], 1'b1};
            end else begin
               srem_ff <= srem_shift;
               root_ff <= {root_ff[cspg_pkg::ROOT_W-2:0], 1'b0};
            end
         end
         cspg_pkg::OP_LEN_INIT: begin
            mul_a_ff <= root_ff;
            mul_b_ff <= cspg_pkg::ROOT_W'(cspg_pkg::USEC_PER_SEC);
            prod_ff  <= '0;
         end
         cspg_pkg::OP_DIV_INIT: begin
            den_ff  <= cspg_pkg::DEN_W'(feed_ff) * cspg_pkg::DEN_W'(total_ff[cmd.axis]);
            div_ff  <= {prod_ff[cspg_pkg::LENP_W-1:0], cspg_pkg::SHIFT_W'(0)};
            drem_ff <= '0;
         end
         cspg_pkg::OP_DIV_STEP: begin
            drem_ff <= div_ge ? cspg_pkg::DEN_W'(drem_shift - {1'b0, den_ff})
                              : drem_shift[cspg_pkg::DEN_W-1:0];
            div_ff  <= {div_ff[cspg_pkg::NUM_W-2:0], div_ge};
         end
         default: ;
      endcase
      if (cmd.out_load) begin
         out_ff.step_pulses <= pulses_ff;
         out_ff.directions  <= dir_ff;
         out_ff.busy_res    <= moving_ff;
         out_ff.move_done   <= move_done_ff;
         out_ff.rejected    <= rej_ff;
      end
   end

   assign status.func     = func_ff;
   assign status.moving   = moving_ff;
   assign status.steps_nz = steps_nz;
   assign rsp_data        = out_ff;

endmodule

// File: sv/coordinated_step_pulse_generator_top.sv
// Top level of the coordinated step pulse generator.
// Each request is handled on its own. A tick with a move in progress passes through decode,
// one step per axis, the time update and the output load before its response is valid; any
// other request that sets up no move, an idle tick included, passes through decode and the output load.
// A move is set up by one shared shift-add multiplier (one bit a cycle), a
// one-bit-a-cycle root unit and a one-bit-a-cycle restoring divider run once per moving
// axis (at most three axes move).
// A new request is taken while the previous response still waits on the output.
module coordinated_step_pulse_generator_top (
   input  logic       clock,
   input  logic       reset,
   cspg_req_if.sink   req_chan,
   cspg_rsp_if.source rsp_chan,
   cspg_csr_if.sink   csr_chan
);

   cspg_pkg::cmd_type      cmd;
   cspg_pkg::status_type   status;
   cspg_pkg::rsp_data_type rsp_data;

   assign csr_chan.ready = 1'b1;

   cspg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   cspg_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .req_func     (req_chan.func),
      .req_target_x (req_chan.target_x),
      .req_target_y (req_chan.target_y),
      .req_target_z (req_chan.target_z),
      .req_target_e (req_chan.target_e),
      .csr_write    (csr_chan.valid),
      .csr_index    (csr_chan.index),
      .csr_data     (csr_chan.data),
      .rsp_data     (rsp_data)
   );

   assign rsp_chan.step_pulses = rsp_data.step_pulses;
   assign rsp_chan.directions  = rsp_data.directions;
   assign rsp_chan.busy_res    = rsp_data.busy_res;
   assign rsp_chan.move_done   = rsp_data.move_done;
   assign rsp_chan.rejected    = rsp_data.rejected;

endmodule

// File: sv/cspg_checker.sv
// Port-level checks of the step pulse generator, bound to the top level.
module cspg_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [3:0] step_pulses,
   input logic       busy_res,
   input logic       move_done,
   input logic       rejected
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && move_done |-> !busy_res)
      else $error("finished move still reported busy");

   a_reject_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rejected |-> busy_res && !move_done && step_pulses == 4'd0)
      else $error("refused request with side effects");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request taken while one is in progress");

endmodule

bind coordinated_step_pulse_generator_top cspg_checker u_cspg_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .step_pulses (rsp_chan.step_pulses),
   .busy_res    (rsp_chan.busy_res),
   .move_done   (rsp_chan.move_done),
   .rejected    (rsp_chan.rejected)
);

// File: tb/tb_top.sv
// Self-checking testbench of the coordinated step pulse generator.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] FUNC_SPARE = 2'd3;
   localparam int         WATCH_LIMIT = 20000;
   localparam int         HOLD_CYCLES = 400;

   typedef struct packed {
      logic [1:0]                     func;
      logic [cspg_pkg::IN_W-1:0]      tx;
      logic [cspg_pkg::IN_W-1:0]      ty;
      logic [cspg_pkg::IN_W-1:0]      tz;
      logic [cspg_pkg::IN_W-1:0]      te;
   } request_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   cspg_req_if req_if ();
   cspg_rsp_if rsp_if ();
   cspg_csr_if csr_if ();

   coordinated_step_pulse_generator_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   always #6 clock = ~clock;

   // Shadow of the block's registers and move state.
   logic [15:0]       sh_mps [3];
   logic [15:0]       sh_feed;
   logic              sh_mode;
   cspg_pkg::pos_type sh_pos [4];
   cspg_pkg::pos_type sh_tgt [4];
   logic [63:0]       sh_total [4];
   logic [63:0]       sh_done [4];
   logic [63:0]       sh_iv [4];
   logic [63:0]       sh_isum [4];
   logic [63:0]       sh_elapsed;
   logic [3:0]        sh_dir;
   logic              sh_moving;

   request_type            pending_q [$];
   cspg_pkg::rsp_data_type expected_q [$];

   int errors = 0;
   int n_moves = 0, n_finished = 0, n_refused = 0, n_pulses = 0, n_checked = 0;

   function automatic logic [63:0] sat48(input logic [63:0] v);
      return (v > 64'(cspg_pkg::SUM_MAX)) ? 64'(cspg_pkg::SUM_MAX) : v;
   endfunction

   function automatic logic [63:0] exact_root(input logic [127:0] s);
      logic [63:0]  r;
      logic [63:0]  c;
      logic [127:0] c2;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
         c  = r | (64'd1 << b);
         c2 = 128'(c) * 128'(c);
         if (c2 <= s) r = c;
      end
      return r;
   endfunction

   function automatic logic [63:0] step_period(input logic [63:0] len, input logic [63:0] steps);
      logic [127:0] num;
      logic [127:0] q;
      logic [63:0]  v;
      num = (128'(len) * 128'd1000000) << (cspg_pkg::INTERVAL_FRAC_BITS + 4);
      if (sh_feed == 0) begin
         v = 64'(cspg_pkg::IV_MAX);
      end else begin
         q = num / (128'(sh_feed) * 128'(steps));
         q = q >> 16;
         v = (q > 128'(cspg_pkg::IV_MAX)) ? 64'(cspg_pkg::IV_MAX) : q[63:0];
      end
      if (v < 64'(cspg_pkg::IV_MIN)) v = 64'(cspg_pkg::IV_MIN);
      return v;
   endfunction

   function automatic cspg_pkg::rsp_data_type predict_response(input request_type rq);
      cspg_pkg::rsp_data_type r;
      cspg_pkg::pos_type      tv [4];
      logic                   all_met;
      logic                   any;
      int                     skip;
      longint                 d;
      logic [63:0]            travel;
      logic [127:0]           sq;
      logic [63:0]            len;
      r = '0;
      tv[0] = rq.tx;
      tv[1] = rq.ty;
      tv[2] = rq.tz;
      tv[3] = rq.te;
      if (rq.func == cspg_pkg::FUNC_TICK) begin
         if (sh_moving) begin
            all_met = 1'b1;
            for (int i = 0; i < 4; i++) begin
               if (sh_done[i] < sh_total[i] &&
                   (sh_elapsed << cspg_pkg::INTERVAL_FRAC_BITS) >= sh_isum[i]) begin
                  r.step_pulses[i] = 1'b1;
                  sh_isum[i] = sat48(sh_isum[i] + sh_iv[i]);
                  sh_done[i]++;
               end
               if (sh_done[i] < sh_total[i]) all_met = 1'b0;
            end
            sh_elapsed = sat48(sh_elapsed + 1);
            if (all_met) begin
               sh_pos = sh_tgt;
               sh_moving = 1'b0;
               r.move_done = 1'b1;
            end
         end
      end else if (rq.func == cspg_pkg::FUNC_MOVE) begin
         if (sh_moving) begin
            r.rejected = 1'b1;
         end else begin
            skip = sh_mode ? 2 : 3;
            sq = '0;
            any = 1'b0;
            sh_dir = '0;
            for (int i = 0; i < 4; i++) begin
               d = longint'(tv[i]) - longint'(sh_pos[i]);
               if (!(tv[i] > sh_pos[i])) sh_dir[i] = 1'b1;
               if (i == skip) begin
                  sh_tgt[i] = sh_pos[i];
                  sh_total[i] = 0;
               end else begin
                  sh_tgt[i] = tv[i];
                  sh_total[i] = (d < 0) ? 64'(-d) : 64'(d);
               end
               sh_done[i] = 0;
               sh_isum[i] = 0;
               sh_iv[i] = 0;
               if (i < 3 && i != skip) begin
                  travel = sh_total[i] * 64'(sh_mps[i]);
                  sq += 128'(travel) * 128'(travel);
               end
               if (sh_total[i] != 0) any = 1'b1;
            end
            len = exact_root(sq);
            for (int i = 0; i < 4; i++)
               if (sh_total[i] != 0) sh_iv[i] = step_period(len, sh_total[i]);
            sh_elapsed = 0;
            if (any) begin
               sh_moving = 1'b1;
            end else begin
               sh_pos = sh_tgt;
               r.move_done = 1'b1;
            end
         end
      end else if (rq.func == cspg_pkg::FUNC_SETPOS) begin
         if (sh_moving) r.rejected = 1'b1;
         else sh_pos = tv;
      end
      r.directions = sh_dir;
      r.busy_res = sh_moving;
      return r;
   endfunction

   task automatic issue(input logic [1:0] fn, input logic [cspg_pkg::IN_W-1:0] a,
                        input logic [cspg_pkg::IN_W-1:0] b,
                        input logic [cspg_pkg::IN_W-1:0] c,
                        input logic [cspg_pkg::IN_W-1:0] e);
      request_type            rq;
      cspg_pkg::rsp_data_type r;
      rq = '{fn, a, b, c, e};
      r = predict_response(rq);
      if (fn == cspg_pkg::FUNC_MOVE && !r.rejected) n_moves++;
      if (r.move_done) n_finished++;
      if (r.rejected) n_refused++;
      n_pulses += $countones(r.step_pulses);
      pending_q.push_back(rq);
      expected_q.push_back(r);
   endtask

   function automatic logic [cspg_pkg::IN_W-1:0] rnd_field();
      return cspg_pkg::IN_W'($urandom());
   endfunction

   // Target near the current position, flipped inward where it would wrap.
   function automatic logic [cspg_pkg::IN_W-1:0] near(input int axis, input int maxd);
      longint v;
      int     dl;
      dl = int'($urandom_range(0, 2 * maxd)) - maxd;
      v = longint'(sh_pos[axis]) + dl;
      if (v > 8388607 || v < -8388608) v = longint'(sh_pos[axis]) - dl;
      return cspg_pkg::IN_W'(v);
   endfunction

   // Starts a move and feeds ticks until it ends, with refused and spare-code requests mixed in.
   task automatic run_move(input int maxd);
      int skip;
      logic [cspg_pkg::IN_W-1:0] t [4];
      skip = sh_mode ? 2 : 3;
      for (int i = 0; i < 4; i++)
         t[i] = (i == skip && $urandom_range(0, 1)) ? rnd_field() : near(i, maxd);
      issue(cspg_pkg::FUNC_MOVE, t[0], t[1], t[2], t[3]);
      while (sh_moving) begin
         case ($urandom_range(0, 19))
            0: issue(cspg_pkg::FUNC_MOVE, rnd_field(), rnd_field(), rnd_field(), rnd_field());
            1: issue(cspg_pkg::FUNC_SETPOS, rnd_field(), rnd_field(), rnd_field(), rnd_field());
            2: issue(FUNC_SPARE, rnd_field(), rnd_field(), rnd_field(), rnd_field());
            default: issue(cspg_pkg::FUNC_TICK, rnd_field(), rnd_field(), rnd_field(),
                           rnd_field());
         endcase
      end
   endtask

   task automatic drain();
      while (pending_q.size() != 0 || expected_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(input cspg_pkg::reg_index_type idx, input logic [15:0] val);
      @(posedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= val;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      case (idx)
         cspg_pkg::REG_MPS_X: sh_mps[0] = val;
         cspg_pkg::REG_MPS_Y: sh_mps[1] = val;
         cspg_pkg::REG_MPS_Z: sh_mps[2] = val;
         cspg_pkg::REG_FEED:  sh_feed = val;
         cspg_pkg::REG_MODE:  sh_mode = val[0];
         default: ;
      endcase
   endtask

   task automatic set_up(input logic [15:0] mx, input logic [15:0] my, input logic [15:0] mz,
                         input logic [15:0] fd, input logic md);
      drain();
      write_reg(cspg_pkg::REG_MPS_X, mx);
      write_reg(cspg_pkg::REG_MPS_Y, my);
      write_reg(cspg_pkg::REG_MPS_Z, mz);
      write_reg(cspg_pkg::REG_FEED, fd);
      write_reg(cspg_pkg::REG_MODE, {15'd0, md});
   endtask

   task automatic random_items(input int count, input int maxd);
      int start;
      start = n_checked + pending_q.size();
      while (n_checked + pending_q.size() < start + count) begin
         case ($urandom_range(0, 9))
            0, 1: issue(cspg_pkg::FUNC_SETPOS, rnd_field(), rnd_field(), rnd_field(),
                        rnd_field());
            2:    issue(FUNC_SPARE, rnd_field(), rnd_field(), rnd_field(), rnd_field());
            3:    issue(cspg_pkg::FUNC_TICK, rnd_field(), rnd_field(), rnd_field(),
                        rnd_field());
            default: run_move(maxd);
         endcase
         while (pending_q.size() > 40) @(posedge clock);
      end
   endtask

   // Request driver.
   int tx_gap = 0;
   logic tx_burst = 1'b0;
   request_type cur;
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_if.ready) begin
         if (tx_gap > 0 && !tx_burst) begin
            tx_gap <= tx_gap - 1;
            req_if.valid <= 1'b0;
         end else if (pending_q.size() != 0) begin
            cur = pending_q.pop_front();
            req_if.valid    <= 1'b1;
            req_if.func     <= cur.func;
            req_if.target_x <= cur.tx;
            req_if.target_y <= cur.ty;
            req_if.target_z <= cur.tz;
            req_if.target_e <= cur.te;
            tx_gap <= ($urandom_range(0, 9) < 6) ? 0 :
                      ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(20, 80);
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Long receiver hold-off, counted here once it is requested.
   logic hold_go = 1'b0;
   logic rx_hold = 1'b0;
   int   hold_cnt = 0;
   always @(posedge clock) begin
      if (hold_go && hold_cnt < HOLD_CYCLES) begin
         hold_cnt <= hold_cnt + 1;
         rx_hold <= 1'b1;
      end else begin
         rx_hold <= 1'b0;
      end
   end

   int rx_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (rx_hold) begin
         rsp_if.ready <= 1'b0;
      end else if (rx_gap > 0 && !tx_burst) begin
         rx_gap <= rx_gap - 1;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
         if ($urandom_range(0, 9) < 3)
            rx_gap <= ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(20, 100);
      end
   end

   task automatic report_mismatch(input string what, input logic [7:0] got, input logic [7:0] want);
      errors++;
      $display("MISMATCH response %0d %s: got %0h expected %0h", n_checked, what, got, want);
   endtask

   // Response monitor.
   cspg_pkg::rsp_data_type want;
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_q.size() == 0) begin
            report_mismatch("unexpected response", 8'd0, 8'd0);
         end else begin
            want = expected_q.pop_front();
            if (rsp_if.step_pulses !== want.step_pulses)
               report_mismatch("step_pulses", 8'(rsp_if.step_pulses), 8'(want.step_pulses));
            if (rsp_if.directions !== want.directions)
               report_mismatch("directions", 8'(rsp_if.directions), 8'(want.directions));
            if (rsp_if.busy_res !== want.busy_res)
               report_mismatch("busy_res", 8'(rsp_if.busy_res), 8'(want.busy_res));
            if (rsp_if.move_done !== want.move_done)
               report_mismatch("move_done", 8'(rsp_if.move_done), 8'(want.move_done));
            if (rsp_if.rejected !== want.rejected)
               report_mismatch("rejected", 8'(rsp_if.rejected), 8'(want.rejected));
            n_checked <= n_checked + 1;
         end
      end
   end

   int quiet = 0;
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready) || reset) begin
         quiet <= 0;
      end else if (quiet >= WATCH_LIMIT) begin
         $display("Timeout: no handshake for %0d cycles", WATCH_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   initial begin
      req_if.valid = 1'b0;
      req_if.func = '0;
      req_if.target_x = '0;
      req_if.target_y = '0;
      req_if.target_z = '0;
      req_if.target_e = '0;
      rsp_if.ready = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.index = '0;
      csr_if.data = '0;
      sh_mps[0] = 16'd819;
      sh_mps[1] = 16'd819;
      sh_mps[2] = 16'd164;
      sh_feed = 16'd800;
      sh_mode = 1'b0;
      for (int i = 0; i < 4; i++) begin
         sh_pos[i] = '0; sh_tgt[i] = '0; sh_total[i] = 0; sh_done[i] = 0;
         sh_iv[i] = 0; sh_isum[i] = 0;
      end
      sh_elapsed = 0;
      sh_dir = '0;
      sh_moving = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed part at the reset settings: idle tick, spare code, extremes.
      issue(cspg_pkg::FUNC_TICK, 24'h7FFFFF, 24'h800000, 24'h000000, 24'hFFFFFF);
      issue(FUNC_SPARE, 24'hFFFFFF, 24'h000000, 24'h7FFFFF, 24'h800000);
      issue(cspg_pkg::FUNC_SETPOS, 24'h7FFFFF, 24'h800000, 24'h000000, 24'hFFFFFF);
      issue(cspg_pkg::FUNC_MOVE, 24'h7FFFFF, 24'h800000, 24'h000000, 24'hFFFFFF);
      issue(cspg_pkg::FUNC_MOVE, 24'h7FFFFE, 24'h800001, 24'h000001, 24'h000000);
      issue(cspg_pkg::FUNC_MOVE, 24'h0, 24'h0, 24'h0, 24'h0);
      issue(cspg_pkg::FUNC_SETPOS, 24'h123456, 24'h0, 24'h0, 24'h0);
      issue(FUNC_SPARE, 24'h0, 24'h0, 24'h0, 24'h0);
      issue(cspg_pkg::FUNC_TICK, 24'h0, 24'h0, 24'h0, 24'h0);
      issue(cspg_pkg::FUNC_TICK, 24'h0, 24'h0, 24'h0, 24'h0);
      issue(cspg_pkg::FUNC_SETPOS, 24'h800000, 24'h7FFFFF, 24'hFFFFFF, 24'h000000);
      drain();

      // Only E moves first in XYE mode, so the length is zero; then X, Y and E move. Z is left out.
      set_up(16'd1, 16'd1, 16'd1, 16'hFFFF, 1'b1);
      issue(cspg_pkg::FUNC_MOVE, 24'h800000, 24'h7FFFFF, 24'h000000, 24'h000005);
      while (sh_moving) issue(cspg_pkg::FUNC_TICK, 24'h0, 24'h0, 24'h0, 24'h0);
      issue(cspg_pkg::FUNC_MOVE, 24'h800008, 24'h7FFFF9, 24'h7FFFFF, 24'h000003);
      while (sh_moving) issue(cspg_pkg::FUNC_TICK, 24'h0, 24'h0, 24'h0, 24'h0);

      random_items(100, 30);
      // The receiver holds off while requests keep coming.
      hold_go = 1'b1;
      random_items(60, 30);
      // The sender pauses until every response is back.
      while (expected_q.size() != 0) @(posedge clock);
      random_items(40, 30);

      set_up(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1, 1'b0);
      random_items(80, 1);
      set_up(16'd819, 16'd819, 16'd164, 16'd800, 1'b0);
      random_items(60, 1);
      set_up(16'd1, 16'd1, 16'd1, 16'hFFFF, 1'b0);
      tx_burst = 1'b1;
      random_items(60, 40);
      tx_burst = 1'b0;
      set_up(16'($urandom_range(1, 64)), 16'($urandom_range(1, 64)),
             16'($urandom_range(1, 64)), 16'($urandom_range(30000, 65535)), 1'b1);
      random_items(100, 20);
      set_up(16'($urandom_range(1, 64)), 16'($urandom_range(1, 64)),
             16'($urandom_range(1, 64)), 16'($urandom_range(30000, 65535)), 1'b0);
      random_items(100, 20);

      while (pending_q.size() != 0 || expected_q.size() != 0) @(posedge clock);
      repeat (600) @(posedge clock);
      $display("Checked %0d responses: %0d moves started, %0d finished, %0d refused,",
               n_checked, n_moves, n_finished, n_refused);
      $display("%0d step pulses, across six register settings in both axis modes.", n_pulses);
      if (errors == 0 && expected_q.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
